[hdl/fault_line_heightfield_top_defines.svh]
// ----------------------------------------------------------------------------
// fault line heightfield assertion macros
// shared concurrent check macros, clocked on clock and quiet during reset
// ----------------------------------------------------------------------------
`ifndef FAULT_LINE_HEIGHTFIELD_TOP_DEFINES_SVH
`define FAULT_LINE_HEIGHTFIELD_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// expression holds at every edge out of reset
`define FLH_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// antecedent in this cycle implies consequent in the next
`define FLH_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`else

`define FLH_ASSERT_ALWAYS(lbl, expr, msg)
`define FLH_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[hdl/flh_pkg.sv]
// ----------------------------------------------------------------------------
// flh_pkg
// sizes, register codes and constant tables of the fault line heightfield
// ----------------------------------------------------------------------------
package flh_pkg;

   localparam int GRID_SIZE  = 256;
   localparam int GRID_BITS  = $clog2(GRID_SIZE);
   localparam int CELL_BITS  = 2 * GRID_BITS;
   localparam int CELL_COUNT = GRID_SIZE * GRID_SIZE;

   localparam int HGT_W      = 40;
   localparam int DY_W       = HGT_W + 2;
   localparam int PD_W       = GRID_BITS + 20;
   localparam int P_W        = 20;
   localparam int ANG_W      = 17;
   localparam int CNT_W      = 12;
   localparam int DISP_W     = CNT_W + 1;
   localparam int GAIN_W     = 16;
   localparam int MODE_W     = 2;
   localparam int DIR_W      = 16;
   localparam int FRAC_W     = 16;
   localparam int IDX_W      = 8;

   localparam int REQ_DATA_W = 2 * DIR_W + FRAC_W + 2 * IDX_W;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = HGT_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TOTAL = 2'd2;

   // fault shapes
   localparam logic [MODE_W-1:0] MODE_STEP = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SINE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_COS  = 2'd2;

   localparam logic [GAIN_W-1:0] GAIN_RESET  = 16'd256;
   localparam logic [CNT_W-1:0]  TOTAL_RESET = 12'd100;

   // half diagonal in Q16, floor(sqrt(2 * (GRID_SIZE/2)^2) * 2^16)
   localparam logic [24:0] D_Q16 = 25'd11863283;

   localparam int SINE_LIM   = 102892;
   localparam int COS_LIM    = 205783;
   localparam int HALF_PI    = 102944;
   localparam int SINE_W_LIM = 3 * (SINE_LIM + 1);
   localparam int COS_OFS_Q  = COS_LIM + 1;
   localparam int COS_OFS    = 3 * COS_OFS_Q;
   localparam int WAVE_BIAS  = 768 / GRID_SIZE;

   // divisor selects: taylor stages then the divide by three
   localparam logic [2:0] DIV_LAST_STG = 3'd4;
   localparam logic [2:0] DIV_BY3      = 3'd5;

   function automatic logic [6:0] div_const(input logic [2:0] sel);
      logic [6:0] k;
      case (sel)
         3'd0:    k = 7'd110;
         3'd1:    k = 7'd72;
         3'd2:    k = 7'd42;
         3'd3:    k = 7'd20;
         3'd4:    k = 7'd6;
         default: k = 7'd3;
      endcase
      return k;
   endfunction

   // floor(2^32 / k)
   function automatic logic [31:0] div_recip(input logic [2:0] sel);
      logic [31:0] r;
      case (sel)
         3'd0:    r = 32'd39045157;
         3'd1:    r = 32'd59652323;
         3'd2:    r = 32'd102261126;
         3'd3:    r = 32'd214748364;
         3'd4:    r = 32'd715827882;
         default: r = 32'd1431655765;
      endcase
      return r;
   endfunction

endpackage

[hdl/fault_line_heightfield_top.sv]
// a read word loads its cell into the memory read register on acceptance; ST_READ then
// moves it into the result register once that is free, and the block takes no new word
// until it is back in idle; a fault word walks all GRID_SIZE^2 cells, one at a time,
// with the single shared 32x32 multiplier and a read-modify-write of each cell
// no clearing pass: reset marks the field empty and the first fault fills it
// reset (synchronous, active high) sets state, csr registers, counter and field flag
`include "fault_line_heightfield_top_defines.svh"

// ----------------------------------------------------------------------------
// fault_line_heightfield_top
// square heightfield raised and lowered by fault lines, one cell at a time
// ----------------------------------------------------------------------------
module fault_line_heightfield_top (
   input  logic                              clock,
   input  logic                              reset,
   // request words
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // dir_cos[15:0], dir_sin[31:16], offset_frac[47:32], cell_row[55:48],
   // cell_col[63:56]
   input  logic [flh_pkg::REQ_DATA_W-1:0]    req_tdata,
   // kind[0]: 0 fault line, 1 cell read
   input  logic [flh_pkg::REQ_USER_W-1:0]    req_tuser,
   // result words
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // cell_height[39:0]
   output logic [flh_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [flh_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [flh_pkg::CSR_DATA_W-1:0]    csr_data
);
   import flh_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE, ST_READ, ST_SETUP, ST_INIT, ST_CELL, ST_SCALE, ST_ARG,
      ST_DIV_R, ST_DIV_B, ST_DIV_F, ST_SIN_X, ST_SIN_X2, ST_SIN_M, ST_SIN_D,
      ST_SIN_F, ST_SIN_R, ST_WAVE, ST_GAIN, ST_APPLY
   } state_type;

   localparam logic RET_ARG  = 1'b0;
   localparam logic RET_SINE = 1'b1;

   localparam logic [30:0] Q30_ONE = 31'h4000_0000;
   localparam logic signed [PD_W-1:0] PD_COS_HI = PD_W'(COS_OFS);
   localparam logic signed [PD_W-1:0] PD_COS_LO = PD_W'(-3 * COS_LIM);
   localparam logic signed [DY_W-1:0] HGT_MAX_X = DY_W'((64'd1 << (HGT_W - 1)) - 64'd1);
   localparam logic signed [DY_W-1:0] HGT_MIN_X = -HGT_MAX_X - DY_W'(1);

   // angle mapping for the cosine wave: cos(p) = +-sin(arg)
   function automatic logic [ANG_W:0] trig_map(input logic signed [P_W-1:0] p);
      logic [P_W-1:0] mag;
      logic [ANG_W:0] res;
      mag = p[P_W-1] ? P_W'(-p) : P_W'(p);
      if (mag <= P_W'(HALF_PI)) begin
         res = {1'b0, ANG_W'(P_W'(HALF_PI) - mag)};
      end else begin
         res = {1'b1, ANG_W'(mag - P_W'(HALF_PI))};
      end
      return res;
   endfunction

   // state and registers
   state_type                  state_ff, state_in;
   logic [MODE_W-1:0]          mode_ff, mode_in;
   logic [GAIN_W-1:0]          gain_ff, gain_in;
   logic [CNT_W-1:0]           total_ff, total_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       filled_ff, filled_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [HGT_W-1:0]           rsp_data_ff, rsp_data_in;
   logic                       in_range_ff, in_range_in;
   logic signed [DIR_W-1:0]    a_ff, a_in;
   logic signed [DIR_W-1:0]    b_ff, b_in;
   logic [FRAC_W-1:0]          u_ff, u_in;
   logic signed [DISP_W-1:0]   disp_ff, disp_in;
   logic [GRID_BITS-1:0]       row_ff, row_in;
   logic [GRID_BITS-1:0]       col_ff, col_in;
   logic signed [PD_W-1:0]     pd_ff, pd_in;
   logic signed [PD_W-1:0]     row_pd_ff, row_pd_in;
   logic signed [64:0]         prod_ff, prod_in;
   logic [ANG_W-1:0]           ang_ff, ang_in;
   logic                       cneg_ff, cneg_in;
   logic [31:0]                x2_ff, x2_in;
   logic [30:0]                t_ff, t_in;
   logic [2:0]                 stg_ff, stg_in;
   logic [31:0]                div_m_ff, div_m_in;
   logic [2:0]                 div_sel_ff, div_sel_in;
   logic [31:0]                div_q_ff, div_q_in;
   logic                       div_ret_ff, div_ret_in;
   logic signed [DY_W-1:0]     dy_ff, dy_in;

   // height memory
   logic [HGT_W-1:0]           mem [CELL_COUNT];
   logic [HGT_W-1:0]           mem_rd_ff;
   logic                       mem_re, mem_we;
   logic [CELL_BITS-1:0]       mem_raddr, mem_waddr;
   logic [HGT_W-1:0]           mem_wdata;

   // shared multiplier
   logic [31:0]                mul_a, mul_b;
   logic                       mul_neg;
   logic [63:0]                mul_raw;

   // helpers
   logic signed [PD_W-1:0]     pd_neg;
   logic [31:0]                pd_mag;
   logic signed [DY_W-1:0]     disp_x;
   logic [DISP_W-1:0]          disp_mag;
   logic signed [64:0]         prod_neg;
   logic [31:0]                prod_mag;
   logic signed [64:0]         scale_w;
   logic [30:0]                x_val;
   logic [32:0]                sine_rnd;
   logic [6:0]                 div_k;
   logic [32:0]                div_r;
   logic [31:0]                div_quo;
   logic [31:0]                t_next;
   logic [PD_W-1:0]            cos_w;
   logic signed [P_W-1:0]      cos_p;
   logic [ANG_W:0]             map_q, map_hi, map_lo;
   logic signed [DY_W-1:0]     old_h, sum_h, sat_h;
   logic                       last_col, last_row;
   logic signed [DIR_W:0]      ab_sum;
   logic signed [PD_W-1:0]     c_q16, init_pd;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign mul_raw   = mul_a * mul_b;
   assign prod_in   = mul_neg ? -$signed({1'b0, mul_raw}) : $signed({1'b0, mul_raw});

   assign pd_neg    = -pd_ff;
   assign pd_mag    = pd_ff[PD_W-1] ? 32'(unsigned'(pd_neg)) : 32'(unsigned'(pd_ff));
   assign disp_x    = {{(DY_W-DISP_W){disp_ff[DISP_W-1]}}, disp_ff};
   assign disp_mag  = disp_ff[DISP_W-1] ? DISP_W'(-disp_ff) : DISP_W'(disp_ff);
   assign prod_neg  = -prod_ff;
   assign prod_mag  = prod_ff[64] ? prod_neg[31:0] : prod_ff[31:0];
   assign scale_w   = prod_ff >>> 8;
   assign x_val     = {ang_ff, 14'd0};
   assign sine_rnd  = prod_ff[62:30] + 33'h0000_4000;
   assign div_k     = div_const(div_sel_ff);
   assign div_r     = {1'b0, div_m_ff} - prod_ff[32:0];
   assign div_quo   = div_q_ff + ((div_r >= {26'd0, div_k}) ? 32'd1 : 32'd0);
   assign t_next    = {1'b0, Q30_ONE} - div_quo;
   assign cos_w     = unsigned'(pd_ff + PD_COS_HI);
   assign cos_p     = $signed({1'b0, div_q_ff[P_W-2:0]}) - P_W'(COS_OFS_Q);
   assign map_q     = trig_map(cos_p);
   assign map_hi    = trig_map(P_W'(COS_LIM));
   assign map_lo    = trig_map(P_W'(-COS_LIM));
   assign old_h     = filled_ff ? DY_W'($signed(mem_rd_ff)) : '0;
   assign sum_h     = old_h + dy_ff;
   assign sat_h     = (sum_h > HGT_MAX_X) ? HGT_MAX_X :
                      (sum_h < HGT_MIN_X) ? HGT_MIN_X : sum_h;
   assign last_col  = (col_ff == GRID_BITS'(GRID_SIZE - 1));
   assign last_row  = (row_ff == GRID_BITS'(GRID_SIZE - 1));
   assign ab_sum    = DIR_W'(0) + a_ff + b_ff;
   assign c_q16     = PD_W'(prod_ff[64:16]) - PD_W'(D_Q16);
   assign init_pd   = c_q16 - (PD_W'(ab_sum) <<< GRID_BITS);

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      gain_in     = gain_ff;
      total_in    = total_ff;
      count_in    = count_ff;
      filled_in   = filled_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      in_range_in = in_range_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      u_in        = u_ff;
      disp_in     = disp_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      pd_in       = pd_ff;
      row_pd_in   = row_pd_ff;
      ang_in      = ang_ff;
      cneg_in     = cneg_ff;
      x2_in       = x2_ff;
      t_in        = t_ff;
      stg_in      = stg_ff;
      div_m_in    = div_m_ff;
      div_sel_in  = div_sel_ff;
      div_q_in    = div_q_ff;
      div_ret_in  = div_ret_ff;
      dy_in       = dy_ff;
      mul_a       = '0;
      mul_b       = '0;
      mul_neg     = 1'b0;
      mem_re      = 1'b0;
      mem_raddr   = {row_ff, col_ff};
      mem_we      = 1'b0;
      mem_waddr   = {row_ff, col_ff};
      mem_wdata   = sat_h[HGT_W-1:0];

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         unique case (csr_index)
            REG_MODE:  mode_in  = csr_data[MODE_W-1:0];
            REG_GAIN:  gain_in  = csr_data[GAIN_W-1:0];
            REG_TOTAL: total_in = csr_data[CNT_W-1:0];
            default:   ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser[0]) begin
                  mem_re      = 1'b1;
                  mem_raddr   = {req_tdata[48 +: GRID_BITS], req_tdata[56 +: GRID_BITS]};
                  in_range_in = (int'(req_tdata[55:48]) < GRID_SIZE) &&
                                (int'(req_tdata[63:56]) < GRID_SIZE);
                  state_in    = ST_READ;
               end else begin
                  a_in     = $signed(req_tdata[15:0]);
                  b_in     = $signed(req_tdata[31:16]);
                  u_in     = req_tdata[47:32];
                  disp_in  = $signed({1'b0, total_ff}) - $signed({1'b0, count_ff});
                  state_in = ST_SETUP;
               end
            end
         end
         ST_READ: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = (filled_ff && in_range_ff) ? mem_rd_ff : '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SETUP: begin
            // u * 2d
            mul_a    = 32'(u_ff);
            mul_b    = 32'({D_Q16, 1'b0});
            state_in = ST_INIT;
         end
         ST_INIT: begin
            row_in    = '0;
            col_in    = '0;
            pd_in     = init_pd;
            row_pd_in = init_pd;
            state_in  = ST_CELL;
         end
         ST_CELL: begin
            mem_re = 1'b1;
            unique case (mode_ff)
               MODE_STEP: begin
                  dy_in    = (pd_ff > 0) ? (disp_x <<< 8) : -(disp_x <<< 8);
                  state_in = ST_APPLY;
               end
               MODE_SINE: begin
                  mul_a    = pd_mag;
                  mul_b    = 32'(gain_ff);
                  mul_neg  = pd_ff[PD_W-1];
                  state_in = ST_SCALE;
               end
               MODE_COS: begin
                  if (pd_ff >= PD_COS_HI) begin
                     {cneg_in, ang_in} = map_hi;
                     state_in = ST_SIN_X;
                  end else if (pd_ff < PD_COS_LO) begin
                     {cneg_in, ang_in} = map_lo;
                     state_in = ST_SIN_X;
                  end else begin
                     div_m_in   = 32'(cos_w);
                     div_sel_in = DIV_BY3;
                     div_ret_in = RET_ARG;
                     div_q_in   = '0;
                     state_in   = ST_DIV_R;
                  end
               end
               default: begin
                  dy_in    = '0;
                  state_in = ST_APPLY;
               end
            endcase
         end
         ST_SCALE: begin
            cneg_in = 1'b0;
            if (prod_ff[64]) begin
               ang_in   = '0;
               state_in = ST_SIN_X;
            end else if (scale_w >= 65'(SINE_W_LIM)) begin
               ang_in   = ANG_W'(SINE_LIM);
               state_in = ST_SIN_X;
            end else begin
               div_m_in   = scale_w[31:0];
               div_sel_in = DIV_BY3;
               div_ret_in = RET_ARG;
               state_in   = ST_DIV_R;
            end
         end
         ST_ARG: begin
            if (mode_ff == MODE_SINE) begin
               ang_in  = div_q_ff[ANG_W-1:0];
               cneg_in = 1'b0;
            end else begin
               {cneg_in, ang_in} = map_q;
            end
            state_in = ST_SIN_X;
         end
         ST_DIV_R: begin
            mul_a    = div_m_ff;
            mul_b    = div_recip(div_sel_ff);
            state_in = ST_DIV_B;
         end
         ST_DIV_B: begin
            div_q_in = prod_ff[63:32];
            mul_a    = prod_ff[63:32];
            mul_b    = 32'(div_k);
            state_in = ST_DIV_F;
         end
         ST_DIV_F: begin
            if (div_ret_ff == RET_SINE) begin
               t_in = t_next[30:0];
               if (stg_ff == DIV_LAST_STG) begin
                  state_in = ST_SIN_F;
               end else begin
                  stg_in   = stg_ff + 3'd1;
                  state_in = ST_SIN_M;
               end
            end else begin
               div_q_in = div_quo;
               state_in = ST_ARG;
            end
         end
         ST_SIN_X: begin
            mul_a    = 32'(x_val);
            mul_b    = 32'(x_val);
            state_in = ST_SIN_X2;
         end
         ST_SIN_X2: begin
            x2_in    = prod_ff[61:30];
            t_in     = Q30_ONE;
            stg_in   = '0;
            state_in = ST_SIN_M;
         end
         ST_SIN_M: begin
            mul_a    = x2_ff;
            mul_b    = 32'(t_ff);
            state_in = ST_SIN_D;
         end
         ST_SIN_D: begin
            div_m_in   = prod_ff[61:30];
            div_sel_in = stg_ff;
            div_ret_in = RET_SINE;
            state_in   = ST_DIV_R;
         end
         ST_SIN_F: begin
            mul_a    = 32'(x_val);
            mul_b    = 32'(t_ff);
            state_in = ST_SIN_R;
         end
         ST_SIN_R: begin
            // rounded sine in q15 times displacement
            mul_a    = 32'(sine_rnd[32:15]);
            mul_b    = 32'(disp_mag);
            mul_neg  = cneg_ff ^ disp_ff[DISP_W-1];
            state_in = ST_WAVE;
         end
         ST_WAVE: begin
            if (mode_ff == MODE_SINE) begin
               dy_in    = DY_W'(prod_ff >>> 7) - (disp_x <<< 7);
               state_in = ST_APPLY;
            end else begin
               mul_a    = prod_mag;
               mul_b    = 32'(gain_ff);
               mul_neg  = prod_ff[64];
               state_in = ST_GAIN;
            end
         end
         ST_GAIN: begin
            dy_in    = (disp_x <<< 8) - DY_W'(WAVE_BIAS) + DY_W'(prod_ff >>> 15);
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            mem_we = 1'b1;
            if (last_col) begin
               col_in = '0;
               if (last_row) begin
                  count_in  = count_ff + CNT_W'(1);
                  filled_in = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  row_in    = row_ff + GRID_BITS'(1);
                  row_pd_in = row_pd_ff + (PD_W'(b_ff) <<< 1);
                  pd_in     = row_pd_ff + (PD_W'(b_ff) <<< 1);
                  state_in  = ST_CELL;
               end
            end else begin
               col_in   = col_ff + GRID_BITS'(1);
               pd_in    = pd_ff + (PD_W'(a_ff) <<< 1);
               state_in = ST_CELL;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_STEP;
         gain_ff      <= GAIN_RESET;
         total_ff     <= TOTAL_RESET;
         count_ff     <= '0;
         filled_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         stg_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         gain_ff      <= gain_in;
         total_ff     <= total_in;
         count_ff     <= count_in;
         filled_ff    <= filled_in;
         rsp_valid_ff <= rsp_valid_in;
         stg_ff       <= stg_in;
      end
      rsp_data_ff <= rsp_data_in;
      in_range_ff <= in_range_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      u_ff        <= u_in;
      disp_ff     <= disp_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      pd_ff       <= pd_in;
      row_pd_ff   <= row_pd_in;
      prod_ff     <= prod_in;
      ang_ff      <= ang_in;
      cneg_ff     <= cneg_in;
      x2_ff       <= x2_in;
      t_ff        <= t_in;
      div_m_ff    <= div_m_in;
      div_sel_ff  <= div_sel_in;
      div_q_ff    <= div_q_in;
      div_ret_ff  <= div_ret_in;
      dy_ff       <= dy_in;
   end

   // height memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rd_ff <= mem[mem_raddr];
      end
   end

   `FLH_ASSERT_ALWAYS(a_stage_range, stg_ff <= DIV_LAST_STG, "taylor stage out of range")
   `FLH_ASSERT_ALWAYS(a_div_fix, (state_ff != ST_DIV_F) || (div_r < {25'd0, div_k, 1'b0}), "quotient estimate off by more than one")
   `FLH_ASSERT_ALWAYS(a_sine_arg, (state_ff != ST_SIN_X) || (ang_ff <= ANG_W'(HALF_PI)), "sine argument above half pi")
   `FLH_ASSERT_NEXT(a_fault_count, (state_ff == ST_APPLY) && last_col && last_row, count_ff == CNT_W'($past(count_ff) + 1'b1), "fault counter did not advance")

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the fault line heightfield: fault lines in every
// shape mode, cell reads checked against a bit-exact predictor of the field
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import flh_pkg::*;

   localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
   localparam logic              KIND_FAULT = 1'b0;
   localparam logic              KIND_READ  = 1'b1;
   localparam longint HGT_HI = 64'sd549755813887;
   localparam longint HGT_LO = -HGT_HI - 1;
   localparam longint Q30_ONE = 64'sd1 << 30;
   // the limit allows for about a dozen faults in all, the slowest in sine and cosine mode
   localparam longint CYCLE_LIMIT = 64'd60_000_000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic [REQ_USER_W-1:0]  req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   fault_line_heightfield_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted state of the block
   longint              field_hgt [CELL_COUNT];
   logic [MODE_W-1:0]   shape_mode;
   logic [GAIN_W-1:0]   wave_gain;
   logic [CNT_W-1:0]    planned_faults;
   logic [CNT_W-1:0]    faults_done;

   logic [HGT_W-1:0]    height_q [$];   // heights of reads still in flight
   int                  errors = 0;
   longint              cycles = 0;
   bit                  calm = 1'b0;    // no idling once set
   bit                  long_hold = 1'b0;
   int                  stall_left = 0;

   // ---------------------------------------------------------------- helpers
   function automatic longint fdiv(input longint v, input longint m);
      longint q;
      q = v / m;
      if ((v % m) != 0 && v < 0) q--;
      return q;
   endfunction

   // q15 sine of a q16 angle in 0..pi/2, odd taylor series in q30
   function automatic longint sine_q15(input longint ang);
      longint unsigned x, x2, t;
      if (ang < 0) ang = 0;
      x  = longint'(ang) << 14;
      x2 = (x * x) >> 30;
      t  = Q30_ONE - x2 / 110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 6;
      return longint'((((x * t) >> 30) + (64'd1 << 14)) >> 15);
   endfunction

   function automatic longint cosine_q15(input longint ang);
      longint a;
      a = (ang < 0) ? -ang : ang;
      if (a <= HALF_PI) return sine_q15(HALF_PI - a);
      return -sine_q15(a - HALF_PI);
   endfunction

   // one fault line over the whole predicted field
   task automatic apply_fault(input logic signed [DIR_W-1:0] cs,
                              input logic signed [DIR_W-1:0] sn,
                              input logic [FRAC_W-1:0] frac);
      longint d, c, disp, pd, p, dy, h;
      d = longint'(D_Q16);
      c = ((longint'(frac) * 2 * d) >>> 16) - d;
      disp = longint'(planned_faults) - longint'(faults_done);
      for (int j = 0; j < GRID_SIZE; j++) begin
         for (int i = 0; i < GRID_SIZE; i++) begin
            pd = (longint'(i - GRID_SIZE / 2) * longint'(cs)
                  + longint'(j - GRID_SIZE / 2) * longint'(sn)) * 2 + c;
            case (shape_mode)
               MODE_STEP: dy = (pd > 0) ? disp * 256 : -disp * 256;
               MODE_SINE: begin
                  p = fdiv(pd * longint'(wave_gain), 768);
                  if (p > SINE_LIM) p = SINE_LIM;
                  else if (p < 0) p = 0;
                  dy = fdiv(sine_q15(p) * disp, 128) - disp * 128;
               end
               MODE_COS: begin
                  p = fdiv(pd, 3);
                  if (p > COS_LIM) p = COS_LIM;
                  else if (p < -COS_LIM) p = -COS_LIM;
                  dy = disp * 256 - WAVE_BIAS
                       + fdiv(cosine_q15(p) * disp * longint'(wave_gain), 32768);
               end
               default: dy = 0;
            endcase
            h = field_hgt[j * GRID_SIZE + i] + dy;
            if (h > HGT_HI) h = HGT_HI;
            else if (h < HGT_LO) h = HGT_LO;
            field_hgt[j * GRID_SIZE + i] = h;
         end
      end
      faults_done = faults_done + 1'b1;
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d, want %0d at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   // ------------------------------------------------------------ result side
   // rsp_tready: random stall bursts, plus a long hold when asked
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 14);
      end
      rsp_tready <= !long_hold && !(stall_left > 0) && !reset;
   end

   // compare each result word with the oldest predicted height
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (height_q.size() == 0) begin
            report_mismatch("unexpected word, height", longint'(signed'(rsp_tdata)), 0);
         end else begin
            if (rsp_tdata !== height_q[0])
               report_mismatch("cell_height", longint'(signed'(rsp_tdata)),
                               longint'(signed'(height_q[0])));
            void'(height_q.pop_front());
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("** fault_line_heightfield_top: FAILED **");
         $finish;
      end
   end

   // ---------------------------------------------------------- request side
   // one request word; returns once it is accepted, valid still high
   task automatic send_word(input logic kind, input logic [DIR_W-1:0] cs,
                            input logic [DIR_W-1:0] sn, input logic [FRAC_W-1:0] frac,
                            input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col);
      int gap;
      gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {col, row, frac, sn, cs};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (kind == KIND_READ)
         height_q.push_back(field_hgt[int'(row) * GRID_SIZE + int'(col)][HGT_W-1:0]);
      else
         apply_fault(cs, sn, frac);
   endtask

   task automatic read_cell(input int row, input int col);
      send_word(KIND_READ, DIR_W'($urandom), DIR_W'($urandom), FRAC_W'($urandom),
                IDX_W'(row), IDX_W'(col));
   endtask

   task automatic fault_line(input int cs, input int sn, input int frac);
      send_word(KIND_FAULT, DIR_W'(cs), DIR_W'(sn), FRAC_W'(frac),
                IDX_W'($urandom), IDX_W'($urandom));
   endtask

   task automatic req_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // sender pauses until every read has come back
   task automatic drain();
      req_idle();
      while (height_q.size() != 0) @(posedge clock);
   endtask

   // a trailing read only returns once an earlier fault has finished
   task automatic settle();
      read_cell($urandom_range(0, 255), $urandom_range(0, 255));
      drain();
      repeat (16) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_MODE:  shape_mode     = val[MODE_W-1:0];
         REG_GAIN:  wave_gain      = val[GAIN_W-1:0];
         REG_TOTAL: planned_faults = val[CNT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic read_spots();
      read_cell(0, 0);
      read_cell(255, 255);
      read_cell(0, 255);
      read_cell(255, 0);
      read_cell(128, 128);
   endtask

   // ------------------------------------------------------------- the tests
   // field starts cleared, corners of the index range
   task automatic test_cleared_field();
      read_cell(0, 0);
      read_cell(255, 255);
      read_cell(0, 255);
   endtask

   // step faults at extreme directions and offsets, reset registers
   task automatic test_step_faults();
      fault_line(32767, 0, 0);
      fault_line(-32768, -32768, 65535);
      read_spots();
      settle();
   endtask

   // displacement drops to negative and to zero, then the largest total
   task automatic test_displacement();
      csr_write(REG_GAIN, 16'd0);
      csr_write(REG_TOTAL, 16'd1);            // counter is 2 here: disp -1
      fault_line(12345, -23456, 40000);
      settle();
      csr_write(REG_TOTAL, 16'd3);            // counter is 3: disp zero
      fault_line(-1, 1, 1);
      settle();
      csr_write(REG_TOTAL, 16'd4095);
      fault_line(23170, 23170, 32768);
      read_spots();
      settle();
   endtask

   task automatic test_sine_ramp();
      csr_write(REG_MODE, CSR_DATA_W'(MODE_SINE));
      csr_write(REG_GAIN, 16'd700);
      fault_line(-28378, 16384, 20000);
      read_spots();
      settle();
   endtask

   task automatic test_cosine_wave();
      csr_write(REG_MODE, CSR_DATA_W'(MODE_COS));
      csr_write(REG_GAIN, 16'hFFFF);
      fault_line(16384, 28378, 50000);
      read_spots();
      settle();
   endtask

   // mode 3 leaves heights alone but still counts
   task automatic test_unused_mode();
      csr_write(REG_MODE, CSR_DATA_W'(MODE_NONE));
      fault_line(-20000, 30000, 1000);
      read_cell(17, 200);
      settle();
      csr_write(REG_MODE, CSR_DATA_W'(MODE_STEP));
      csr_write(REG_GAIN, GAIN_RESET);
      csr_write(REG_TOTAL, 16'd2000);
   endtask

   // hold results off while reads pile up and stall the request side
   task automatic test_backpressure();
      req_idle();
      long_hold = 1'b1;
      fork
         begin
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
         end
      join_none
      repeat (24) read_cell($urandom_range(0, 255), $urandom_range(0, 255));
      drain();
   endtask

   // mostly reads, now and then a step fault with random content
   task automatic test_random_mix();
      for (int n = 0; n < 40; n++) begin
         if (n == 30) calm = 1'b1;
         if ($urandom_range(0, 19) == 0)
            fault_line($urandom, $urandom, $urandom);
         else
            read_cell($urandom_range(0, 255), $urandom_range(0, 255));
      end
      drain();
   endtask

   initial begin
      for (int k = 0; k < CELL_COUNT; k++) field_hgt[k] = 0;
      shape_mode     = MODE_STEP;
      wave_gain      = GAIN_RESET;
      planned_faults = TOTAL_RESET;
      faults_done    = '0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_cleared_field();
      test_step_faults();
      test_displacement();
      test_sine_ramp();
      test_cosine_wave();
      test_unused_mode();
      test_backpressure();
      test_random_mix();

      repeat (50) @(posedge clock);
      if (errors == 0 && height_q.size() == 0) begin
         $display("** fault_line_heightfield_top: PASSED **");
      end else begin
         $display("** fault_line_heightfield_top: FAILED **");
      end
      $finish;
   end

endmodule

[fault_line_heightfield_top.f]
+incdir+hdl
hdl/flh_pkg.sv
hdl/fault_line_heightfield_top.sv
tb/tb_top.sv
